>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL of the GF(256) recurrence generator.
// No dependencies; SYNTH selects the empty versions for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define GFR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define GFR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define GFR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define GFR_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> hdl/gfr_pkg.sv
// Shared types, codes and GF(256) arithmetic for the recurrence generator.
// No dependencies.
package gfr_pkg;

    localparam int BYTE_W      = 8;
    localparam int TAP_IDX_W   = 6;
    localparam int TAP_COUNT_W = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int S_TDATA_W   = 24;

    // field polynomial x^8+x^7+x^6+x^5+x^4+x^3+1, low byte
    localparam logic [BYTE_W-1:0] FIELD_POLY_LOW = 8'hF9;

    // item kinds carried in s_tuser
    localparam logic REQ_GENERATE = 1'b0;
    localparam logic REQ_LOAD     = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET    = 1'b1;

    // memory control from the sequencer
    typedef struct packed {
        logic rd_en;
        logic coef_we;
        logic hist_we;
    } gfr_ctl_t;

    // shift-and-add multiply, reduced by the field polynomial
    function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] p,
                                                 input logic [BYTE_W-1:0] q);
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] acc;
        acc = '0;
        a   = p;
        for (int b = 0; b < BYTE_W; b++) begin
            if (q[b]) begin
                acc = acc ^ a;
            end
            if (a[BYTE_W-1]) begin
                a = {a[BYTE_W-2:0], 1'b0} ^ FIELD_POLY_LOW;
            end else begin
                a = {a[BYTE_W-2:0], 1'b0};
            end
        end
        return acc;
    endfunction

endpackage

>>> hdl/gfr_tap_ram.sv
// One tap table: synchronous RAM, one write and one read port, registered read.
// Per-entry valid bits make unwritten entries read as zero. Uses gfr_pkg.
module gfr_tap_ram #(
    parameter int DEPTH = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [gfr_pkg::BYTE_W-1:0]      wdata,
    input  logic                            re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [gfr_pkg::BYTE_W-1:0]      rdata
);

    logic [gfr_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]           valid_reg;
    logic [gfr_pkg::BYTE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= valid_reg[raddr] ? mem[raddr] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (we) begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/gfr_seq.sv
// Sequencer: takes items, walks the active taps one per cycle through the
// tap RAMs, shifts the history and hands out the result. Uses gfr_pkg.
module gfr_seq #(
    parameter int MAX_TAPS = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 in_req,
    input  logic [gfr_pkg::TAP_IDX_W-1:0]        in_idx,
    input  logic [gfr_pkg::BYTE_W-1:0]           in_seed,
    input  logic [gfr_pkg::TAP_COUNT_W-1:0]      tap_count,
    input  logic [gfr_pkg::BYTE_W-1:0]           offset_constant,
    input  logic [gfr_pkg::BYTE_W-1:0]           coef_q,
    input  logic [gfr_pkg::BYTE_W-1:0]           hist_q,
    output gfr_pkg::gfr_ctl_t                    ctl,
    output logic [(MAX_TAPS > 1 ? $clog2(MAX_TAPS) : 1)-1:0] rd_addr,
    output logic [(MAX_TAPS > 1 ? $clog2(MAX_TAPS) : 1)-1:0] coef_waddr,
    output logic [(MAX_TAPS > 1 ? $clog2(MAX_TAPS) : 1)-1:0] hist_waddr,
    output logic [gfr_pkg::BYTE_W-1:0]           hist_wdata,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output logic [gfr_pkg::BYTE_W-1:0]           res_data
);

    localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int KW = $clog2(MAX_TAPS + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN} state_t;

    state_t                     state_reg;
    logic [KW-1:0]              k_reg;
    logic [KW-1:0]              ptr_reg;
    logic [AW-1:0]              paddr_reg;
    logic                       pv_reg;
    logic [gfr_pkg::BYTE_W-1:0] acc_reg;

    logic                       accept;
    logic                       load_ok;
    logic                       issue;
    logic                       last;
    logic                       fire;
    logic                       shift_we;
    logic [KW-1:0]              k_eff;
    logic [KW-1:0]              k_last;
    logic [gfr_pkg::BYTE_W-1:0] acc_upd;

    // clamp tap count to 1..MAX_TAPS
    always_comb begin
        if (tap_count == '0) begin
            k_eff = KW'(1);
        end else if ({2'b00, tap_count} > 9'(MAX_TAPS)) begin
            k_eff = KW'(MAX_TAPS);
        end else begin
            k_eff = KW'(tap_count);
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign load_ok  = accept && (in_req == gfr_pkg::REQ_LOAD)
                      && ({3'b000, in_idx} < 9'(MAX_TAPS));
    assign issue    = (state_reg == ST_RUN) && (ptr_reg < k_reg);
    assign k_last   = k_reg - KW'(1);
    assign last     = (state_reg == ST_RUN) && pv_reg && (KW'(paddr_reg) == k_last);
    assign fire     = (state_reg == ST_FIN) && res_ready;
    assign shift_we = (state_reg == ST_RUN) && pv_reg && (paddr_reg != '0);
    assign acc_upd  = acc_reg ^ gfr_pkg::gf_mul(coef_q, hist_q);

    assign ctl.rd_en   = issue;
    assign ctl.coef_we = load_ok;
    assign ctl.hist_we = load_ok || shift_we || fire;
    assign rd_addr     = AW'(ptr_reg);
    assign coef_waddr  = AW'(in_idx);

    // history write: load, shift down by one, or the new byte at k-1
    always_comb begin
        priority if (load_ok) begin
            hist_waddr = AW'(in_idx);
            hist_wdata = in_seed;
        end else if (shift_we) begin
            hist_waddr = paddr_reg - AW'(1);
            hist_wdata = hist_q;
        end else begin
            hist_waddr = AW'(k_last);
            hist_wdata = acc_reg;
        end
    end

    assign res_valid = fire;
    assign res_data  = acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pv_reg    <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    pv_reg <= 1'b0;
                    if (accept && (in_req == gfr_pkg::REQ_GENERATE)) begin
                        k_reg     <= k_eff;
                        ptr_reg   <= '0;
                        acc_reg   <= offset_constant;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    pv_reg    <= issue;
                    paddr_reg <= AW'(ptr_reg);
                    if (issue) begin
                        ptr_reg <= ptr_reg + KW'(1);
                    end
                    if (pv_reg) begin
                        acc_reg <= acc_upd;
                    end
                    if (last) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    pv_reg <= 1'b0;
                    if (res_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> hdl/gf256_recurrence_generator.sv
// GF(256) linear recurrence byte generator, top level.
// Load item: written when taken, no result. Generate item with k active taps: the
// sequencer walks the k taps, then hands the result to the output register; the next
// item is taken after that hand-over. One tap per cycle, set by the single RAM read port.
// The output register lets the next item be taken while a result waits.
// Reset (aresetn low, synchronous): tables read as zero, tap_count = 1, c = 0.
`include "assert_macros.svh"

module gf256_recurrence_generator #(
    parameter int MAX_TAPS = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input items
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [5:0] tap_index, [13:6] tap_coefficient, [21:14] seed_value, [23:22] zero
    input  logic [gfr_pkg::S_TDATA_W-1:0]      s_tdata,
    // [0] req_type
    input  logic [0:0]                         s_tuser,
    // result items
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] random_byte
    output logic [gfr_pkg::BYTE_W-1:0]         m_tdata,
    // configuration writes
    input  logic                               cfg_wr_en,
    input  logic [gfr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gfr_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

    localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

    // configuration registers
    logic [gfr_pkg::TAP_COUNT_W-1:0] tap_count_reg;
    logic [gfr_pkg::BYTE_W-1:0]      offset_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_count_reg <= gfr_pkg::TAP_COUNT_W'(1);
            offset_reg    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                gfr_pkg::CFG_TAP_COUNT: tap_count_reg <= cfg_wr_data[gfr_pkg::TAP_COUNT_W-1:0];
                gfr_pkg::CFG_OFFSET:    offset_reg    <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // unpack the input item
    logic [gfr_pkg::TAP_IDX_W-1:0] in_idx;
    logic [gfr_pkg::BYTE_W-1:0]    in_coef;
    logic [gfr_pkg::BYTE_W-1:0]    in_seed;

    assign in_idx  = s_tdata[5:0];
    assign in_coef = s_tdata[13:6];
    assign in_seed = s_tdata[21:14];

    // sequencer <-> tap RAMs
    gfr_pkg::gfr_ctl_t          ctl;
    logic [AW-1:0]              rd_addr;
    logic [AW-1:0]              coef_waddr;
    logic [AW-1:0]              hist_waddr;
    logic [gfr_pkg::BYTE_W-1:0] hist_wdata;
    logic [gfr_pkg::BYTE_W-1:0] coef_q;
    logic [gfr_pkg::BYTE_W-1:0] hist_q;
    logic                       res_valid;
    logic                       res_ready;
    logic [gfr_pkg::BYTE_W-1:0] res_data;

    gfr_tap_ram #(.DEPTH(MAX_TAPS)) u_coef_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (ctl.coef_we),
        .waddr   (coef_waddr),
        .wdata   (in_coef),
        .re      (ctl.rd_en),
        .raddr   (rd_addr),
        .rdata   (coef_q)
    );

    gfr_tap_ram #(.DEPTH(MAX_TAPS)) u_hist_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (ctl.hist_we),
        .waddr   (hist_waddr),
        .wdata   (hist_wdata),
        .re      (ctl.rd_en),
        .raddr   (rd_addr),
        .rdata   (hist_q)
    );

    gfr_seq #(.MAX_TAPS(MAX_TAPS)) u_seq (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .in_req          (s_tuser[0]),
        .in_idx          (in_idx),
        .in_seed         (in_seed),
        .tap_count       (tap_count_reg),
        .offset_constant (offset_reg),
        .coef_q          (coef_q),
        .hist_q          (hist_q),
        .ctl             (ctl),
        .rd_addr         (rd_addr),
        .coef_waddr      (coef_waddr),
        .hist_waddr      (hist_waddr),
        .hist_wdata      (hist_wdata),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res_data        (res_data)
    );

    // output register: the sequencer hands over only when this slot frees
    logic                       m_tvalid_reg;
    logic [gfr_pkg::BYTE_W-1:0] m_tdata_reg;

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_tdata_reg <= res_data;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // checks
    `GFR_ASSERT_IMP(a_res_slot_free, aclk, aresetn, res_valid, res_ready)
    `GFR_ASSERT_IMP(a_coef_write_on_load, aclk, aresetn, ctl.coef_we,
                    s_tvalid && s_tready && (s_tuser[0] == gfr_pkg::REQ_LOAD))
    `GFR_ASSERT_NXT(a_generate_busy, aclk, aresetn,
                    s_tvalid && s_tready && (s_tuser[0] == gfr_pkg::REQ_GENERATE), !s_tready)

endmodule
